@@ rtl/core/pif_pkg.sv @@
// Package: shared constants, types and helpers of the integer formatter.
package pif_pkg;

    localparam int MaxChars = 64;

    typedef enum logic [2:0] {
        CONV_SDEC  = 3'd0,
        CONV_UDEC  = 3'd1,
        CONV_OCT   = 3'd2,
        CONV_HEXL  = 3'd3,
        CONV_HEXU  = 3'd4,
        CONV_PTR   = 3'd5,
        CONV_RSV6  = 3'd6,
        CONV_RSV7  = 3'd7
    } conv_t;

    typedef enum logic [1:0] {
        LEN_32 = 2'd0,
        LEN_16 = 2'd1,
        LEN_64 = 2'd2,
        LEN_RSV = 2'd3
    } len_t;

    localparam logic [2:0] REG_CONV  = 3'd0;
    localparam logic [2:0] REG_LEN   = 3'd1;
    localparam logic [2:0] REG_WIDTH = 3'd2;
    localparam logic [2:0] REG_PREC  = 3'd3;
    localparam logic [2:0] REG_PGIV  = 3'd4;
    localparam logic [2:0] REG_FLAGS = 3'd5;

    // Radix select toward the digit converter.
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // Converter status toward the emitter.
    typedef struct packed {
        logic       done;
        logic [6:0] nd;      // number of digits (0..22)
        logic       mag_zero;
    } conv_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PLAN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        SEG_LPAD,
        SEG_SIGN,
        SEG_PRE,
        SEG_ZPAD,
        SEG_LEAD,
        SEG_DIG,
        SEG_RPAD,
        SEG_END
    } seg_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10)
                c = 8'h30 + {4'd0, d};
            else if (upper)
                c = 8'h37 + {4'd0, d};
            else
                c = 8'h57 + {4'd0, d};
            digit_char = c;
        end
    endfunction

endpackage

@@ rtl/core/pif_digit_conv.sv @@
// Bit-serial digit converter: decimal by double-dabble, octal and hex by bit split.
module pif_digit_conv
    import pif_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [63:0]      mag,
    input  logic [1:0]       radix_sel,   // 0 dec, 1 oct, 2 hex
    input  logic [6:0]       rd_idx,      // digit index from least significant
    output logic [3:0]       rd_digit,
    output conv_stat_t       stat
);

    // 20 BCD digits of decimal; octal and hex read straight from the value.
    logic [79:0] bcd_reg, bcd_next;
    logic [63:0] sh_reg, sh_next;
    logic [63:0] val_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  nd_reg, nd_next;
    logic [6:0]  scan_reg, scan_next;
    logic        scan_on_reg, scan_on_next;
    logic [79:0] adj;
    logic [3:0]  cur_digit;
    logic [6:0]  ndig_max;
    logic [1:0]  rad_reg;

    always_comb
    begin
        for (int k = 0; k < 20; k++)
            adj[4*k +: 4] = (bcd_reg[4*k +: 4] > 4'd4) ?
                            bcd_reg[4*k +: 4] + 4'd3 : bcd_reg[4*k +: 4];
    end

    function automatic logic [3:0] pick(input logic [1:0] r, input logic [79:0] b,
                                        input logic [63:0] v, input logic [6:0] i);
        logic [3:0] d;
        begin
            d = 4'd0;
            case (r)
                RADIX_DEC: d = (i < 7'd20) ? b[i[4:0]*4 +: 4] : 4'd0;
                RADIX_OCT: d = (i < 7'd22) ? {1'b0, 3'((v >> (i * 3)) & 64'h7)} : 4'd0;
                default:   d = (i < 7'd16) ? v[i[3:0]*4 +: 4] : 4'd0;
            endcase
            pick = d;
        end
    endfunction

    assign cur_digit = pick(rad_reg, bcd_reg, val_reg, scan_reg);
    assign rd_digit  = pick(rad_reg, bcd_reg, val_reg, rd_idx);
    assign ndig_max  = (rad_reg == RADIX_DEC) ? 7'd20 :
                       (rad_reg == RADIX_OCT) ? 7'd22 : 7'd16;

    always_comb
    begin
        bcd_next     = bcd_reg;
        sh_next      = sh_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = done_reg;
        nd_next      = nd_reg;
        scan_next    = scan_reg;
        scan_on_next = scan_on_reg;
        if (start)
        begin
            bcd_next     = '0;
            sh_next      = mag;
            cnt_next     = 7'd0;
            busy_next    = (radix_sel == RADIX_DEC);
            scan_on_next = (radix_sel != RADIX_DEC);
            done_next    = 1'b0;
            nd_next      = 7'd0;
            scan_next    = 7'd0;
        end
        else if (busy_reg)
        begin
            // shift in one bit per cycle
            bcd_next = {adj[78:0], sh_reg[63]};
            sh_next  = {sh_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next    = 1'b0;
                scan_on_next = 1'b1;
            end
        end
        else if (scan_on_reg)
        begin
            // find the highest nonzero digit, one digit per cycle
            if (cur_digit != 4'd0)
                nd_next = scan_reg + 7'd1;
            scan_next = scan_reg + 7'd1;
            if (scan_reg + 7'd1 == ndig_max)
            begin
                scan_on_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            scan_on_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            scan_reg    <= '0;
            nd_reg      <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            scan_on_reg <= scan_on_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
            scan_reg    <= scan_next;
            nd_reg      <= nd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        sh_reg  <= sh_next;
        if (start)
        begin
            val_reg <= mag;
            rad_reg <= radix_sel;
        end
    end

    assign stat.done     = done_reg;
    assign stat.nd       = nd_reg;
    assign stat.mag_zero = (nd_reg == 7'd0);

endmodule

@@ rtl/core/printf_integer_formatter_core.sv @@
// Top level: printf-style integer formatter with serial digit conversion.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  input     | value_valid/ready  | value[63:0]
//  output    | out_valid/ready    | char_out[7:0], last
//  config    | cfg_we             | cfg_index[2:0], cfg_data[6:0]
//
// Sequence: the accepting cycle loads the value, then double-dabble runs for decimal
// (not for octal or hex), the converter scans every digit slot to count digits
// (20 decimal, 22 octal, 16 hex), the control sees the converter done, plans the
// segments, then emits one character per cycle while the output is not stalled,
// for up to MaxChars characters, with an idle step at each segment boundary before
// the last character.
// Reset clears the control and the configuration registers.
// An output stall holds the current character and freezes the emit position.
module printf_integer_formatter_core
    import pif_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    output logic        value_ready,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_out,
    output logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    // configuration registers
    logic [2:0] conv_reg;
    logic [1:0] len_reg;
    logic [6:0] fw_reg;
    logic [5:0] prec_reg;
    logic       pg_reg;
    logic [4:0] flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_reg  <= '0;
            len_reg   <= '0;
            fw_reg    <= '0;
            prec_reg  <= '0;
            pg_reg    <= 1'b0;
            flags_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONV:  conv_reg  <= cfg_data[2:0];
                REG_LEN:   len_reg   <= cfg_data[1:0];
                REG_WIDTH: fw_reg    <= cfg_data;
                REG_PREC:  prec_reg  <= cfg_data[5:0];
                REG_PGIV:  pg_reg    <= cfg_data[0];
                REG_FLAGS: flags_reg <= cfg_data[4:0];
                default:   ;
            endcase
        end
    end

    // decode the conversion
    logic  is_ptr, is_sdec, is_oct, is_hex, upper;
    logic [1:0] radix_sel;
    assign is_ptr  = (conv_reg == CONV_PTR);
    assign is_sdec = (conv_reg == CONV_SDEC);
    assign is_oct  = (conv_reg == CONV_OCT);
    assign is_hex  = (conv_reg == CONV_HEXL) || (conv_reg == CONV_HEXU) || is_ptr;
    assign upper   = (conv_reg == CONV_HEXU);
    assign radix_sel = is_hex ? RADIX_HEX : (is_oct ? RADIX_OCT : RADIX_DEC);

    logic f_minus, f_zero, f_plus, f_space, f_hash;
    assign f_minus = flags_reg[0];
    assign f_zero  = flags_reg[1];
    assign f_plus  = flags_reg[2];
    assign f_space = flags_reg[3];
    assign f_hash  = flags_reg[4];

    // length handling and magnitude (one 64-bit negate at load)
    logic [63:0] v_ext, mag_in;
    logic        neg_in;
    always_comb
    begin
        v_ext = value;
        if (!is_ptr)
        begin
            case (len_reg)
                LEN_32:  v_ext = is_sdec ? {{32{value[31]}}, value[31:0]} : {32'd0, value[31:0]};
                LEN_16:  v_ext = is_sdec ? {{48{value[15]}}, value[15:0]} : {48'd0, value[15:0]};
                default: v_ext = value;
            endcase
        end
        neg_in = is_sdec && v_ext[63];
        mag_in = neg_in ? (64'd0 - v_ext) : v_ext;
    end

    state_t     state_reg, state_next;
    logic       neg_reg;
    logic [6:0] rd_idx;
    logic [3:0] rd_digit;
    conv_stat_t cstat;
    logic       start;

    pif_digit_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mag       (mag_in),
        .radix_sel (radix_sel),
        .rd_idx    (rd_idx),
        .rd_digit  (rd_digit),
        .stat      (cstat)
    );

    // segment lengths, computed in the planning cycle
    logic [6:0] nd_reg, lead_reg, pad_reg, npre_reg, total_reg;
    logic       sign_on_reg, zpad_reg;
    logic [7:0] sign_ch_reg;
    logic [6:0] nd_c, lead_c, npre_c, body_c;
    logic       sign_c;
    logic       mz;

    always_comb
    begin
        mz     = cstat.mag_zero;
        nd_c   = cstat.nd;
        if (mz)
            nd_c = (pg_reg && prec_reg == 6'd0 && !is_ptr) ? 7'd0 : 7'd1;
        lead_c = ({1'b0, prec_reg} > nd_c) ? ({1'b0, prec_reg} - nd_c) : 7'd0;
        if (is_oct && f_hash && lead_c == 7'd0 && (!mz || nd_c == 7'd0))
            lead_c = 7'd1;
        npre_c = (is_ptr || (is_hex && f_hash && !mz)) ? 7'd2 : 7'd0;
        sign_c = is_sdec && (neg_reg || f_plus || f_space);
        body_c = {6'd0, sign_c} + npre_c + lead_c + nd_c;
    end

    // emitter
    seg_t       seg_reg, seg_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [6:0] emitted_reg, emitted_next;
    logic [7:0] ch_reg, ch_next;
    logic       last_reg, last_next, ov_reg, ov_next;
    logic [7:0] cur_ch;
    logic       cur_valid;
    logic       ready_for_char;

    // length of a segment
    function automatic logic [6:0] seg_len(input seg_t s, input logic [6:0] pad,
                                           input logic lp, input logic sg,
                                           input logic [6:0] np, input logic zp,
                                           input logic [6:0] ld, input logic [6:0] nd,
                                           input logic rp);
        logic [6:0] l;
        begin
            case (s)
                SEG_LPAD: l = lp ? pad : 7'd0;
                SEG_SIGN: l = {6'd0, sg};
                SEG_PRE:  l = np;
                SEG_ZPAD: l = zp ? pad : 7'd0;
                SEG_LEAD: l = ld;
                SEG_DIG:  l = nd;
                SEG_RPAD: l = rp ? pad : 7'd0;
                default:  l = 7'd0;
            endcase
            seg_len = l;
        end
    endfunction

    logic lpad_on, rpad_on;
    assign lpad_on = !f_minus && !zpad_reg;
    assign rpad_on = f_minus;

    // digit position counts down from the most significant digit
    assign rd_idx = nd_reg - 7'd1 - cnt_reg;

    always_comb
    begin
        case (seg_reg)
            SEG_LPAD: cur_ch = 8'h20;
            SEG_SIGN: cur_ch = sign_ch_reg;
            SEG_PRE:  cur_ch = (cnt_reg == 7'd0) ? 8'h30 : (upper ? 8'h58 : 8'h78);
            SEG_ZPAD: cur_ch = 8'h30;
            SEG_LEAD: cur_ch = 8'h30;
            SEG_DIG:  cur_ch = digit_char(rd_digit, upper);
            SEG_RPAD: cur_ch = 8'h20;
            default:  cur_ch = 8'h20;
        endcase
        cur_valid = (seg_reg != SEG_END) &&
                    (cnt_reg < seg_len(seg_reg, pad_reg, lpad_on, sign_on_reg, npre_reg,
                                       zpad_reg, lead_reg, nd_reg, rpad_on));
    end

    assign ready_for_char = !ov_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        cnt_next     = cnt_reg;
        emitted_next = emitted_reg;
        ch_next      = ch_reg;
        last_next    = last_reg;
        ov_next      = ov_reg;
        start        = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    start      = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (cstat.done)
                    state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                seg_next     = SEG_LPAD;
                cnt_next     = 7'd0;
                emitted_next = 7'd0;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!cur_valid)
                begin
                    // advance to the next segment
                    cnt_next = 7'd0;
                    if (seg_reg == SEG_END || seg_reg == SEG_RPAD)
                    begin
                        seg_next   = SEG_END;
                        if (!ov_next)
                            state_next = ST_IDLE;
                    end
                    else
                        seg_next = seg_t'(seg_reg + 3'd1);
                end
                else if (ready_for_char)
                begin
                    // emit one character; peek for last by total count or the MaxChars limit
                    ch_next      = cur_ch;
                    ov_next      = 1'b1;
                    emitted_next = emitted_reg + 7'd1;
                    last_next    = (emitted_reg + 7'd1 == total_reg) ||
                                   (emitted_reg + 7'd1 == 7'(MaxChars));
                    cnt_next     = cnt_reg + 7'd1;
                    if (last_next)
                    begin
                        seg_next = SEG_END;
                        cnt_next = 7'd0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seg_reg     <= SEG_END;
            cnt_reg     <= '0;
            emitted_reg <= '0;
            ov_reg      <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seg_reg     <= seg_next;
            cnt_reg     <= cnt_next;
            emitted_reg <= emitted_next;
            ov_reg      <= ov_next;
            last_reg    <= last_next;
        end
    end

    logic [6:0] tot_c;
    assign tot_c = (fw_reg > body_c) ? fw_reg : body_c;

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        if (start)
            neg_reg <= neg_in;
        if (state_reg == ST_PLAN)
        begin
            nd_reg      <= nd_c;
            lead_reg    <= lead_c;
            npre_reg    <= npre_c;
            sign_on_reg <= sign_c;
            sign_ch_reg <= neg_reg ? 8'h2D : (f_plus ? 8'h2B : 8'h20);
            pad_reg     <= tot_c - body_c;
            total_reg   <= tot_c;
            zpad_reg    <= !f_minus && f_zero && !pg_reg;
        end
    end

    assign value_ready = (state_reg == ST_IDLE);
    assign out_valid   = ov_reg;
    assign char_out    = ch_reg;
    assign last        = last_reg;

endmodule

@@ rtl/core/pif_checker.sv @@
// Port-level checker for the formatter, bound to the top level.
module pif_checker
    import pif_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        value_valid,
    input logic        value_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  char_out,
    input logic        last
);

    // one value at a time: no new transaction while characters are pending
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !value_ready)
        else $error("input accepted while output pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last))
        else $error("stalled character changed");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && value_ready |=> !value_ready)
        else $error("ready stayed high after a transaction");

    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !char_out[7])
        else $error("non-ASCII character");

endmodule

bind printf_integer_formatter_core pif_checker u_pif_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_out    (char_out),
    .last        (last)
);

@@ tb/sv/tb_top.sv @@
// Testbench of the printf-style integer formatter: directed and random values.
module tb_top
    import pif_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        value_valid;
    logic        value_ready;
    logic [63:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  char_out;
    logic        last;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [6:0]  cfg_data;

    // Shadow copy of the configuration registers
    conv_t      fmt_conv;
    len_t       fmt_len;
    logic [6:0] fmt_width;
    logic [5:0] fmt_prec;
    logic       fmt_pgiv;
    logic [4:0] fmt_flags;

    // Expected characters, each with its last mark in bit 8
    logic [8:0] char_queue[$];
    int         fail_count;
    int         idle_cycles;
    bit         allow_idle;

    printf_integer_formatter_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Build the text of one value and append its characters to the queue.
    task automatic format_value(input logic [63:0] raw);
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        logic [63:0] v;
        logic [63:0] mag;
        logic [7:0]  sign_ch;
        logic [7:0]  dc;
        logic [4:0]  base;
        bit          is_ptr;
        bit          upper;
        bit          hex_pre;
        bit          f_minus;
        bit          f_zero;
        int          nd;
        int          lead;
        int          body;
        int          pad;
        int          n;
        conv_t       cv;
        v       = raw;
        sign_ch = 8'h00;
        cv      = fmt_conv;
        is_ptr  = (cv == CONV_PTR);
        if (cv == CONV_RSV6 || cv == CONV_RSV7)
            cv = CONV_UDEC;
        base    = (cv == CONV_OCT) ? 5'd8 : (cv >= CONV_HEXL) ? 5'd16 : 5'd10;
        upper   = (cv == CONV_HEXU);
        f_minus = fmt_flags[0];
        f_zero  = fmt_flags[1];
        if (cv == CONV_SDEC)
        begin
            if (fmt_len == LEN_32)
                v = {{32{v[31]}}, v[31:0]};
            else if (fmt_len == LEN_16)
                v = {{48{v[15]}}, v[15:0]};
            mag = v[63] ? -v : v;
            if (v[63])
                sign_ch = "-";
            else if (fmt_flags[2])
                sign_ch = "+";
            else if (fmt_flags[3])
                sign_ch = " ";
        end
        else
        begin
            if (!is_ptr && fmt_len == LEN_32)
                v = {32'd0, v[31:0]};
            else if (!is_ptr && fmt_len == LEN_16)
                v = {48'd0, v[15:0]};
            mag = v;
        end
        // Digits, most significant first
        if (mag == 0)
        begin
            if (!(fmt_pgiv && fmt_prec == 0) || is_ptr)
                digits.push_back("0");
        end
        else
        begin
            while (mag != 0)
            begin
                dc = (mag % base < 10) ? 8'h30 + 8'(mag % base) : 8'h57 + 8'(mag % base);
                if (upper && dc >= "a")
                    dc = dc - 8'h20;
                digits.push_front(dc);
                mag = mag / base;
            end
            mag = 1;  // flag as nonzero for the prefix checks below
        end
        nd   = digits.size();
        lead = (fmt_prec > nd) ? fmt_prec - nd : 0;
        if (cv == CONV_OCT && fmt_flags[4] && lead == 0 && (mag != 0 || nd == 0))
            lead = 1;
        hex_pre = is_ptr || (base == 16 && fmt_flags[4] && mag != 0);
        body = (sign_ch != 0) + (hex_pre ? 2 : 0) + lead + nd;
        pad  = (fmt_width > body) ? fmt_width - body : 0;
        if (!f_minus && !(f_zero && !fmt_pgiv))
            repeat (pad) text.push_back(" ");
        if (sign_ch != 0)
            text.push_back(sign_ch);
        if (hex_pre)
        begin
            text.push_back("0");
            text.push_back(upper ? "X" : "x");
        end
        if (!f_minus && f_zero && !fmt_pgiv)
            repeat (pad) text.push_back("0");
        repeat (lead) text.push_back("0");
        foreach (digits[i])
            text.push_back(digits[i]);
        if (f_minus)
            repeat (pad) text.push_back(" ");
        n = (text.size() < MaxChars) ? text.size() : MaxChars;
        for (int i = 0; i < n; i++)
            char_queue.push_back({(i == n - 1), text[i]});
    endtask

    // Send one value; predict at acceptance, then drop valid.
    task automatic send_value(input logic [63:0] data);
        if (allow_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) @(posedge clk);
        value_valid <= 1'b1;
        value       <= data;
        do
            @(posedge clk);
        while (!value_ready);
        format_value(data);
        value_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until all text has arrived, then let the block settle.
    task automatic drain;
        while (char_queue.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Present one register write; the caller drops the write enable at the end.
    task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_CONV:  fmt_conv  = conv_t'(data[2:0]);
            REG_LEN:   fmt_len   = len_t'(data[1:0]);
            REG_WIDTH: fmt_width = data;
            REG_PREC:  fmt_prec  = data[5:0];
            REG_PGIV:  fmt_pgiv  = data[0];
            default:   fmt_flags = data[4:0];
        endcase
    endtask

    task automatic set_format(input conv_t cv, input len_t ln, input int wd,
                              input int pr, input bit pg, input logic [4:0] fl);
        drain();
        write_reg(REG_CONV, 7'(cv));
        write_reg(REG_LEN, 7'(ln));
        write_reg(REG_WIDTH, 7'(wd));
        write_reg(REG_PREC, 7'(pr));
        write_reg(REG_PGIV, 7'(pg));
        write_reg(REG_FLAGS, 7'(fl));
        cfg_we <= 1'b0;
    endtask

    // Boundary values across every conversion and the special cases.
    task automatic test_directed;
        set_format(CONV_SDEC, LEN_32, 0, 0, 0, 5'd0);
        send_value(64'd0);
        send_value(64'h0000_0000_8000_0000);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        set_format(CONV_SDEC, LEN_64, 25, 0, 0, 5'b00110);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'd42);
        set_format(CONV_SDEC, LEN_16, 8, 0, 0, 5'b01001);
        send_value(64'h1234_5678_9ABC_8000);
        set_format(CONV_UDEC, LEN_RSV, 0, 0, 1, 5'd0);
        send_value(64'd0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        set_format(CONV_OCT, LEN_64, 0, 0, 1, 5'b10000);
        send_value(64'd0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        set_format(CONV_HEXL, LEN_64, 20, 0, 0, 5'b10010);
        send_value(64'hDEAD_BEEF_0123_4567);
        send_value(64'd0);
        set_format(CONV_HEXU, LEN_32, 64, 60, 1, 5'b11111);
        send_value(64'hABCD_EF01_2345_6789);
        set_format(CONV_PTR, LEN_16, 10, 0, 1, 5'b00001);
        send_value(64'd0);
        send_value(64'hFFFF_0000_1234_ABCD);
        set_format(CONV_RSV7, LEN_32, 127, 60, 1, 5'b00000);
        send_value(64'd7);
        set_format(CONV_RSV6, LEN_64, 3, 5, 0, 5'b00010);
        send_value(64'd99);
    endtask

    // Random formats, several values per setting.
    task automatic test_random(input int groups, input bit idle_on);
        logic [63:0] v;
        int          r;
        allow_idle = idle_on;
        for (int g = 0; g < groups; g++)
        begin
            set_format(conv_t'($urandom_range(0, 7)), len_t'($urandom_range(0, 3)),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 24),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 12),
                       $urandom_range(0, 1), 5'($urandom_range(0, 31)));
            repeat (6)
            begin
                r = $urandom_range(0, 5);
                v = {$urandom, $urandom};
                if (r == 0)
                    v = 64'd0;
                else if (r == 1)
                    v = v >> $urandom_range(0, 63);
                send_value(v);
            end
        end
    endtask

    // Hold off the sender until every expected character has arrived.
    task automatic test_pause;
        drain();
        send_value({$urandom, $urandom});
    endtask

    // Receiver with random stall bursts while idle is allowed
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (allow_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare each accepted character with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (char_queue.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual char %h last %b",
                         $time, char_out, last);
                fail_count++;
            end
            else
            begin
                if (char_out !== char_queue[0][7:0] || last !== char_queue[0][8])
                begin
                    $display("%0t: mismatch, expected char %h last %b, actual char %h last %b",
                             $time, char_queue[0][7:0], char_queue[0][8], char_out, last);
                    fail_count++;
                end
                void'(char_queue.pop_front());
            end
        end
    end

    // Watchdog: count cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((value_valid && value_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        value_valid = 1'b0;
        value       = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        fail_count  = 0;
        idle_cycles = 0;
        allow_idle  = 1'b1;
        fmt_conv    = CONV_SDEC;
        fmt_len     = LEN_32;
        fmt_width   = '0;
        fmt_prec    = '0;
        fmt_pgiv    = 1'b0;
        fmt_flags   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(10, 1'b1);
        test_pause();
        test_random(5, 1'b0);
        drain();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/pif_pkg.sv
rtl/core/pif_digit_conv.sv
rtl/core/printf_integer_formatter_core.sv
rtl/core/pif_checker.sv
tb/sv/tb_top.sv
